### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// implication or plain property, checked on every rising edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition that must never be seen on a rising edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/core/ffba_pkg.sv
// ---------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and helpers of the first-fit bitmap allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int WORD_BITS = 64;
  localparam int LANES     = 8;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // configuration register indexes
  localparam logic REG_BIT_LIMIT     = 1'b0;
  localparam logic REG_RESULT_OFFSET = 1'b1;

  // result status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_FINISH
  } ffba_state_t;

  // one map word presented to the check unit
  typedef struct packed {
    logic                 v;
    logic                 last;
    logic [WORD_BITS-1:0] data;
    logic [WORD_BITS-1:0] mask;
  } ffba_chk_req_t;

  // registered outcome of the check unit
  typedef struct packed {
    logic       v;
    logic       hit;
    logic       last;
    logic [2:0] lane;
    logic [7:0] data;
    logic [7:0] free;
  } ffba_pick_t;

  // index of the lowest set bit of a byte, zero when none is set
  function automatic logic [2:0] first_set8(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/core/ffba_word_check.sv
// ---------------------------------------------------------------------------
// ffba_word_check
// Registered free-bit check of one 64-bit map word: finds the lowest byte
// lane holding a clear, in-limit bit and hands that byte on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffba_word_check (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   flush,
  input  ffba_pkg::ffba_chk_req_t req,
  output ffba_pkg::ffba_pick_t    pick
);
  import ffba_pkg::*;

  logic [WORD_BITS-1:0] free_bits;
  logic [LANES-1:0]     lane_has;
  logic [2:0]           lane_sel;
  ffba_pick_t           pick_r;
  ffba_pick_t           pick_nxt;

  always_comb begin
    free_bits = ~req.data & req.mask;
    for (int i = 0; i < LANES; i++) begin
      lane_has[i] = |free_bits[i*8 +: 8];
    end
    lane_sel = first_set8(lane_has);

    pick_nxt.v    = req.v && !flush;
    pick_nxt.hit  = |lane_has;
    pick_nxt.last = req.last;
    pick_nxt.lane = lane_sel;
    pick_nxt.data = req.data[lane_sel*8 +: 8];
    pick_nxt.free = free_bits[lane_sel*8 +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_r.v <= 1'b0;
    end else begin
      pick_r.v <= pick_nxt.v;
    end
    pick_r.hit  <= pick_nxt.hit;
    pick_r.last <= pick_nxt.last;
    pick_r.lane <= pick_nxt.lane;
    pick_r.data <= pick_nxt.data;
    pick_r.free <= pick_nxt.free;
  end

  assign pick = pick_r;

  // a hit always carries at least one free bit in the chosen byte
  `ASSERT_CLK(a_hit_has_free, clk, rst_n, (pick_r.v && pick_r.hit) |-> (pick_r.free != 8'd0))

endmodule

### rtl/core/first_fit_bitmap_allocator_unit.sv
// ---------------------------------------------------------------------------
// first_fit_bitmap_allocator_unit
// First-fit bit allocator over a byte-loaded bitmap held in on-chip RAM.
// ---------------------------------------------------------------------------
// The map is kept as BITMAP_BYTES/8 words of 64 bits (BITMAP_BYTES must be a
// multiple of 8). After reset the block sweeps the RAM to zero, one word per
// cycle; in_tready stays low meanwhile, while configuration writes are taken.
// A load item writes its byte when accepted and then goes to ST_FINISH. An
// allocate item streams one RAM word per cycle through the free-bit check unit
// until a word with a free bit or the last word is checked, reading at most
// ceil(limit/64) words; the single RAM read port sets that rate. A zero limit
// reports full without reading the RAM. Each item gives exactly one result,
// held in an output register so the next item is taken while the previous
// result waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_fit_bitmap_allocator_unit #(
  parameter int BITMAP_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] map byte address, [17:10] byte_value, zero pad
  input  logic        in_tuser,   // [0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [12:0] alloc_bit, [44:13] alloc_number, zero pad
  output logic        out_tuser   // [0] status
);
  import ffba_pkg::*;

  localparam int WORDS   = BITMAP_BYTES / 8;
  localparam int NBITS   = BITMAP_BYTES * 8;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WCNT_W  = $clog2(WORDS + 1);
  localparam int LIM_W   = ($clog2(NBITS + 1) > 14) ? $clog2(NBITS + 1) : 14;
  localparam int IDX_W   = WADDR_W + 6;

  // config registers
  logic [13:0] bit_limit_r;
  logic [31:0] result_offset_r;

  // sequencer
  ffba_state_t          state_r, state_nxt;
  logic [WADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [WCNT_W-1:0]    lw_r, lw_nxt;          // whole words inside the limit
  logic [5:0]           rem_r, rem_nxt;        // bits in the partial tail word
  logic [WCNT_W-1:0]    n_words_r, n_words_nxt;
  logic [WORD_BITS-1:0] tail_mask_r, tail_mask_nxt;
  logic [WCNT_W-1:0]    ra_r, ra_nxt;

  // pending result
  logic        res_status_r, res_status_nxt;
  logic [12:0] res_bit_r, res_bit_nxt;
  logic [31:0] res_num_r, res_num_nxt;

  // output register
  logic        out_v_r;
  logic        out_status_r;
  logic [12:0] out_bit_r;
  logic [31:0] out_num_r;
  logic        out_load;

  // RAM and read pipeline
  logic [WORD_BITS-1:0] mem_r [WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rd_v_r, rd_v_nxt;
  logic                 rd_last_r;
  logic [WADDR_W-1:0]   rd_w_r;
  logic [WADDR_W-1:0]   pk_w_r;
  logic [WADDR_W-1:0]   ra_addr;
  logic                 rd_issue;

  logic                 wr_en, wr_full;
  logic [WADDR_W-1:0]   wr_addr;
  logic [2:0]           wr_lane;
  logic [7:0]           wr_byte;

  // fields
  logic       req_type;
  logic [9:0] ld_addr;
  logic [7:0] byte_value;

  logic [LIM_W-1:0] lim_ext, eff_limit;
  logic [2:0]       bit_sel;
  logic [IDX_W-1:0] found_idx;
  logic             flush;
  ffba_chk_req_t    chk_req;
  ffba_pick_t       pick;

  assign req_type   = in_tuser;
  assign ld_addr    = in_tdata[9:0];
  assign byte_value = in_tdata[17:10];

  // configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_limit_r     <= 14'd8192;
      result_offset_r <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BIT_LIMIT:     bit_limit_r     <= cfg_data[13:0];
        REG_RESULT_OFFSET: result_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // limit saturates at the map size
  assign lim_ext   = LIM_W'(bit_limit_r);
  assign eff_limit = (lim_ext > LIM_W'(NBITS)) ? LIM_W'(NBITS) : lim_ext;

  assign ra_addr  = ra_r[WADDR_W-1:0];
  assign rd_issue = (ra_r < n_words_r);

  assign bit_sel   = first_set8(pick.free);
  assign found_idx = {pk_w_r, pick.lane, bit_sel};

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    lw_nxt         = lw_r;
    rem_nxt        = rem_r;
    n_words_nxt    = n_words_r;
    tail_mask_nxt  = tail_mask_r;
    ra_nxt         = ra_r;
    res_status_nxt = res_status_r;
    res_bit_nxt    = res_bit_r;
    res_num_nxt    = res_num_r;
    rd_v_nxt       = 1'b0;
    flush          = 1'b0;
    in_tready      = 1'b0;
    out_load       = 1'b0;
    wr_en          = 1'b0;
    wr_full        = 1'b0;
    wr_addr        = clr_addr_r;
    wr_lane        = 3'd0;
    wr_byte        = 8'd0;

    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_full      = 1'b1;
        clr_addr_nxt = clr_addr_r + WADDR_W'(1);
        if (clr_addr_r == WADDR_W'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (req_type == REQ_LOAD) begin
            // out-of-range loads still report done
            if (32'(ld_addr) < 32'(BITMAP_BYTES)) begin
              wr_en   = 1'b1;
              wr_addr = WADDR_W'(ld_addr >> 3);
              wr_lane = ld_addr[2:0];
              wr_byte = byte_value;
            end
            res_status_nxt = STAT_OK;
            res_bit_nxt    = 13'd0;
            res_num_nxt    = 32'd0;
            state_nxt      = ST_FINISH;
          end else begin
            lw_nxt    = WCNT_W'(eff_limit >> 6);
            rem_nxt   = eff_limit[5:0];
            state_nxt = ST_START;
          end
        end
      end

      ST_START: begin
        tail_mask_nxt = ~({WORD_BITS{1'b1}} << rem_r);
        n_words_nxt   = lw_r + WCNT_W'(rem_r != 6'd0);
        ra_nxt        = '0;
        if (lw_r == '0 && rem_r == 6'd0) begin
          // nothing to search
          res_status_nxt = STAT_FULL;
          res_bit_nxt    = 13'd0;
          res_num_nxt    = 32'd0;
          state_nxt      = ST_FINISH;
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (pick.v && pick.hit) begin
          // set the bit in place and drop words still in flight
          flush          = 1'b1;
          wr_en          = 1'b1;
          wr_addr        = pk_w_r;
          wr_lane        = pick.lane;
          wr_byte        = pick.data | (8'd1 << bit_sel);
          res_status_nxt = STAT_OK;
          res_bit_nxt    = 13'(found_idx);
          res_num_nxt    = 32'(found_idx) + result_offset_r;
          state_nxt      = ST_FINISH;
        end else if (pick.v && pick.last) begin
          flush          = 1'b1;
          res_status_nxt = STAT_FULL;
          res_bit_nxt    = 13'd0;
          res_num_nxt    = 32'd0;
          state_nxt      = ST_FINISH;
        end else if (rd_issue) begin
          rd_v_nxt = 1'b1;
          ra_nxt   = ra_r + WCNT_W'(1);
        end
      end

      ST_FINISH: begin
        if (!out_v_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      ra_r       <= '0;
      rd_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      ra_r       <= ra_nxt;
      rd_v_r     <= rd_v_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lw_r         <= lw_nxt;
    rem_r        <= rem_nxt;
    n_words_r    <= n_words_nxt;
    tail_mask_r  <= tail_mask_nxt;
    res_status_r <= res_status_nxt;
    res_bit_r    <= res_bit_nxt;
    res_num_r    <= res_num_nxt;
    rd_w_r       <= ra_addr;
    rd_last_r    <= (ra_r == n_words_r - WCNT_W'(1));
    pk_w_r       <= rd_w_r;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_bit_r    <= res_bit_r;
      out_num_r    <= res_num_r;
    end
  end

  // map RAM: one write port with byte lanes, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_full) begin
        mem_r[wr_addr] <= '0;
      end else begin
        mem_r[wr_addr][wr_lane*8 +: 8] <= wr_byte;
      end
    end
    rdata_r <= mem_r[ra_addr];
  end

  // tail word is masked to the bits below the limit
  always_comb begin
    chk_req.v    = rd_v_r;
    chk_req.last = rd_last_r;
    chk_req.data = rdata_r;
    chk_req.mask = (WCNT_W'(rd_w_r) == lw_r) ? tail_mask_r : {WORD_BITS{1'b1}};
  end

  ffba_word_check u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .flush (flush),
    .req   (chk_req),
    .pick  (pick)
  );

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_num_r, out_bit_r};

  `ASSERT_NEVER(a_no_accept_in_clear, clk, rst_n, (state_r == ST_CLEAR) && in_tready)
  `ASSERT_CLK(a_scan_bound, clk, rst_n, (state_r == ST_SCAN) |-> (ra_r <= n_words_r))
  `ASSERT_CLK(a_full_is_zero, clk, rst_n, (out_v_r && out_status_r) |-> (out_tdata == 48'd0))

endmodule
